// ===== rtl/core/bqhp_pkg.sv =====
// ----------------------------------------------------------------------------
// bqhp_pkg
// shared constants and types for the biquad highpass filter
// ----------------------------------------------------------------------------
package bqhp_pkg;

  // coefficient format, signed Q2.30
  localparam int COEF_WIDTH = 32;
  localparam int COEF_FRAC  = 30;

  // fraction bits of the recursive state below the sample lsb
  localparam int STATE_FRAC = 16;

  // configuration register indexes
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_A0     = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FEEDBACK_B1 = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FEEDBACK_B2 = 2'd2;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FB   = 5'b00010,
    ST_FIX1 = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_FIX2 = 5'b10000
  } bqhp_state_t;

endpackage

// ===== rtl/core/biquad_highpass_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_highpass_filter
// second-order highpass biquad, bit-serial multiply-accumulate datapath
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload                    | handshake
//  ---------+-----------+----------------------------+----------------------
//  in_      | input     | tdata: sample_in           | tvalid / tready
//  out_     | output    | tdata: sample_out          | tvalid / tready
//  cfg_     | input     | index, wdata (32 bit)      | we, no back-pressure
//
//  one request runs N = max(STATE_WIDTH + 2, 47) steps of the shared serial
//  multiplier per pass
//  the multiplier consumes one state bit per cycle for b1*w1 + b2*w2, then
//  one bit per cycle of the serially formed difference w - 2*w1 + w2 for a0
//  synchronous active-low reset clears state, coefficients and control
//  the result sits in an output register; a new request is taken while it
//  waits, and only the final write-back stalls until the slot is free
//
module biquad_highpass_filter #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH  = 48,
  localparam int TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: sample_in
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [TDATA_WIDTH-1:0]               in_tdata,
  // out_tdata: sample_out
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [TDATA_WIDTH-1:0]               out_tdata,
  input  logic                                 cfg_we,
  input  logic [bqhp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [bqhp_pkg::COEF_WIDTH-1:0]      cfg_wdata
);
  import bqhp_pkg::*;

  // serial step count, long enough for the state width and the rounding points
  localparam int N      = (STATE_WIDTH + 2 > COEF_FRAC + STATE_FRAC + 1) ?
                          STATE_WIDTH + 2 : COEF_FRAC + STATE_FRAC + 1;
  localparam int CNT_W  = $clog2(N + 1);
  localparam int AW     = COEF_WIDTH + 4;
  localparam int LO_W   = N - COEF_FRAC;
  localparam int FW1    = AW + LO_W;
  localparam int FW2    = AW + LO_W - STATE_FRAC;
  localparam int X_STEP = COEF_FRAC + STATE_FRAC;

  bqhp_state_t state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]           acc_r, acc_nxt;
  logic [LO_W-1:0]         lo_r, lo_nxt;
  logic [STATE_WIDTH-1:0]  sh1_r, sh1_nxt;
  logic [STATE_WIDTH-1:0]  sh2_r, sh2_nxt;
  logic [STATE_WIDTH-1:0]  shw_r, shw_nxt;
  logic                    prev1_r, prev1_nxt;
  logic [1:0]              carry_r, carry_nxt;
  logic [SAMPLE_WIDTH-1:0] x_r, x_nxt;
  logic [STATE_WIDTH-1:0]  w_r, w_nxt;
  logic [STATE_WIDTH-1:0]  w1_r, w1_nxt;
  logic [STATE_WIDTH-1:0]  w2_r, w2_nxt;
  logic [COEF_WIDTH-1:0]   a0_r, a0_nxt;
  logic [COEF_WIDTH-1:0]   b1_r, b1_nxt;
  logic [COEF_WIDTH-1:0]   b2_r, b2_nxt;
  logic [SAMPLE_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    in_fire;
  logic                    out_free;
  logic                    last_step;
  logic [AW-1:0]           b1_ext, b2_ext, a0_ext, x_ext;
  logic [AW-1:0]           term1, term2, term, term_s, inj;
  logic                    cin;
  logic [AW-1:0]           sum;
  logic [2:0]              dsum;
  logic                    dbit;
  logic [FW1-1:0]          full1;
  logic [FW1-STATE_WIDTH:0] hi1;
  logic [STATE_WIDTH-1:0]  w_sat;
  logic [FW2-1:0]          full2;
  logic [FW2-SAMPLE_WIDTH:0] hi2;
  logic [SAMPLE_WIDTH-1:0] y_sat;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_WIDTH'(out_data_r);

  assign last_step = (cnt_r == CNT_W'(N - 1));

  // sign-extended operands at accumulator width
  assign b1_ext = {{(AW - COEF_WIDTH){b1_r[COEF_WIDTH-1]}}, b1_r};
  assign b2_ext = {{(AW - COEF_WIDTH){b2_r[COEF_WIDTH-1]}}, b2_r};
  assign a0_ext = {{(AW - COEF_WIDTH){a0_r[COEF_WIDTH-1]}}, a0_r};
  assign x_ext  = {{(AW - SAMPLE_WIDTH){x_r[SAMPLE_WIDTH-1]}}, x_r};

  // serial difference w - 2*w1 + w2, lsb first, +1 enters as the initial carry
  assign dsum      = {2'b00, shw_r[0]} + {2'b00, ~prev1_r} + {2'b00, sh2_r[0]}
                   + {1'b0, carry_r};
  assign dbit      = dsum[0];

  assign term1 = (sh1_r[0] ? b1_ext : '0) + (sh2_r[0] ? b2_ext : '0);
  assign term2 = dbit ? a0_ext : '0;
  assign term  = (state_r == ST_FB) ? term1 : term2;
  // multiplier msb carries negative weight
  assign term_s = last_step ? (~term + AW'(1)) : term;

  // x*2^46 folded into the feedback product, rounding halves injected as carries
  assign inj = ((state_r == ST_FB) && (cnt_r == CNT_W'(X_STEP))) ? x_ext : '0;
  assign cin = ((state_r == ST_FB)  && (cnt_r == CNT_W'(COEF_FRAC - 1))) ||
               ((state_r == ST_MUL) && (cnt_r == CNT_W'(X_STEP - 1)));

  assign sum = acc_r + term_s + inj + AW'(cin);

  // recursive value: product >> 30, saturated to the state width
  assign full1 = {acc_r, lo_r};
  assign hi1   = full1[FW1-1:STATE_WIDTH-1];
  always_comb begin
    if ((&hi1) | ~(|hi1)) begin
      w_sat = full1[STATE_WIDTH-1:0];
    end else if (full1[FW1-1]) begin
      w_sat = {1'b1, {(STATE_WIDTH - 1){1'b0}}};
    end else begin
      w_sat = {1'b0, {(STATE_WIDTH - 1){1'b1}}};
    end
  end

  // output: product >> 46, saturated to the sample width
  assign full2 = {acc_r, lo_r[LO_W-1:STATE_FRAC]};
  assign hi2   = full2[FW2-1:SAMPLE_WIDTH-1];
  always_comb begin
    if ((&hi2) | ~(|hi2)) begin
      y_sat = full2[SAMPLE_WIDTH-1:0];
    end else if (full2[FW2-1]) begin
      y_sat = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    lo_nxt        = lo_r;
    sh1_nxt       = sh1_r;
    sh2_nxt       = sh2_r;
    shw_nxt       = shw_r;
    prev1_nxt     = prev1_r;
    carry_nxt     = carry_r;
    x_nxt         = x_r;
    w_nxt         = w_r;
    w1_nxt        = w1_r;
    w2_nxt        = w2_r;
    a0_nxt        = a0_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_tready;

    // coefficient writes, unknown indexes ignored
    if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_A0:     a0_nxt = cfg_wdata;
        REG_FEEDBACK_B1: b1_nxt = cfg_wdata;
        REG_FEEDBACK_B2: b2_nxt = cfg_wdata;
        default:         ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          x_nxt     = in_tdata[SAMPLE_WIDTH-1:0];
          sh1_nxt   = w1_r;
          sh2_nxt   = w2_r;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_FB;
        end
      end
      ST_FB: begin
        // b1*w1 + b2*w2, one state bit per cycle
        acc_nxt = {sum[AW-1], sum[AW-1:1]};
        lo_nxt  = {sum[0], lo_r[LO_W-1:1]};
        sh1_nxt = {sh1_r[STATE_WIDTH-1], sh1_r[STATE_WIDTH-1:1]};
        sh2_nxt = {sh2_r[STATE_WIDTH-1], sh2_r[STATE_WIDTH-1:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_step) begin
          state_nxt = ST_FIX1;
        end
      end
      ST_FIX1: begin
        w_nxt     = w_sat;
        shw_nxt   = w_sat;
        sh1_nxt   = w1_r;
        sh2_nxt   = w2_r;
        prev1_nxt = 1'b0;
        carry_nxt = 2'd1;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // a0 times the difference, formed bit by bit alongside
        acc_nxt   = {sum[AW-1], sum[AW-1:1]};
        lo_nxt    = {sum[0], lo_r[LO_W-1:1]};
        shw_nxt   = {shw_r[STATE_WIDTH-1], shw_r[STATE_WIDTH-1:1]};
        sh1_nxt   = {sh1_r[STATE_WIDTH-1], sh1_r[STATE_WIDTH-1:1]};
        sh2_nxt   = {sh2_r[STATE_WIDTH-1], sh2_r[STATE_WIDTH-1:1]};
        prev1_nxt = sh1_r[0];
        carry_nxt = dsum[2:1];
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (last_step) begin
          state_nxt = ST_FIX2;
        end
      end
      ST_FIX2: begin
        // write back once the output slot is free
        if (out_free) begin
          out_data_nxt  = y_sat;
          out_valid_nxt = 1'b1;
          w2_nxt        = w1_r;
          w1_nxt        = w_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      w1_r        <= '0;
      w2_r        <= '0;
      a0_r        <= '0;
      b1_r        <= '0;
      b2_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      w1_r        <= w1_nxt;
      w2_r        <= w2_nxt;
      a0_r        <= a0_nxt;
      b1_r        <= b1_nxt;
      b2_r        <= b2_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    lo_r       <= lo_nxt;
    sh1_r      <= sh1_nxt;
    sh2_r      <= sh2_nxt;
    shw_r      <= shw_nxt;
    prev1_r    <= prev1_nxt;
    carry_r    <= carry_nxt;
    x_r        <= x_nxt;
    w_r        <= w_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  // an accepted request starts the feedback pass at step zero
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_FB) && (cnt_r == '0))
    else $error("feedback pass did not start after request");

  // step counter stays inside the serial length
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FB) || (state_r == ST_MUL)) |-> (cnt_r < CNT_W'(N)))
    else $error("serial step counter out of range");

  // a new result appears only from the write-back state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_FIX2))
    else $error("output valid rose outside write-back");

  // state registers move only on write-back
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_FIX2) |=> $stable(w1_r) && $stable(w2_r))
    else $error("recursive state changed outside write-back");

  // write-back never overruns a waiting result
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIX2) && out_valid_r && !out_tready) |=> (state_r == ST_FIX2))
    else $error("write-back overran a pending result");
`endif

endmodule

// ===== test/bqhp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqhp_checker
// watches the sample and coefficient ports of the highpass biquad, keeps its
// own fixed-point copy of the filter and compares every output sample
// ----------------------------------------------------------------------------
module bqhp_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: sample_in
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  input  logic [15:0]                          in_tdata,
  // out_tdata: sample_out
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic [15:0]                          out_tdata,
  input  logic                                 cfg_we,
  input  logic [bqhp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [bqhp_pkg::COEF_WIDTH-1:0]      cfg_wdata,
  output int                                   n_pending,
  output int                                   n_checked,
  output int                                   n_errors
);
  import bqhp_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int STATE_W  = 48;

  logic signed [COEF_WIDTH-1:0] gain_a0;
  logic signed [COEF_WIDTH-1:0] feedback_b1;
  logic signed [COEF_WIDTH-1:0] feedback_b2;
  logic signed [STATE_W-1:0]    recur_w1;
  logic signed [STATE_W-1:0]    recur_w2;

  logic [SAMPLE_W-1:0] expected_samples[$];
  int                  checked_count;
  int                  mismatch_count;

  function automatic logic signed [127:0] clamp_signed(input logic signed [127:0] v,
                                                       input int bits);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
    lo = -(128'sd1 <<< (bits - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one filter step: updates the recursive state, returns the output sample
  function automatic logic [SAMPLE_W-1:0] next_highpass_sample(
      input logic signed [SAMPLE_W-1:0] x);
    logic signed [127:0] x_w, a0_w, b1_w, b2_w, w1_w, w2_w;
    logic signed [127:0] fb, w, diff, y;
    x_w  = x;
    a0_w = gain_a0;
    b1_w = feedback_b1;
    b2_w = feedback_b2;
    w1_w = recur_w1;
    w2_w = recur_w2;
    fb   = b1_w * w1_w + b2_w * w2_w;
    fb   = (fb + (128'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    w    = clamp_signed((x_w <<< STATE_FRAC) + fb, STATE_W);
    diff = w - (w1_w <<< 1) + w2_w;
    y    = (a0_w * diff + (128'sd1 <<< (COEF_FRAC + STATE_FRAC - 1)))
           >>> (COEF_FRAC + STATE_FRAC);
    y    = clamp_signed(y, SAMPLE_W);
    recur_w2 = recur_w1;
    recur_w1 = w[STATE_W-1:0];
    return y[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      gain_a0     = '0;
      feedback_b1 = '0;
      feedback_b2 = '0;
      recur_w1    = '0;
      recur_w2    = '0;
      expected_samples.delete();
      checked_count  = 0;
      mismatch_count = 0;
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out: result with no request outstanding, actual %0d",
                 $signed(out_tdata));
          mismatch_count++;
        end else begin
          want = expected_samples.pop_front();
          checked_count++;
          if (out_tdata !== want) begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   $signed(want), $signed(out_tdata));
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_A0:     gain_a0     = cfg_wdata;
          REG_FEEDBACK_B1: feedback_b1 = cfg_wdata;
          REG_FEEDBACK_B2: feedback_b2 = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_samples.push_back(next_highpass_sample(in_tdata));
    end
    n_pending <= expected_samples.size();
    n_checked <= checked_count;
    n_errors  <= mismatch_count;
  end

endmodule

// ===== test/tb_biquad_highpass_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_biquad_highpass_filter
// drives samples and coefficient settings into the highpass biquad; a
// separate checker predicts each output sample and counts mismatches
// ----------------------------------------------------------------------------
module tb_biquad_highpass_filter;
  import bqhp_pkg::*;

  // register index past the last coefficient, the block must ignore it
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

  localparam int SETTLE_CYCLES = 110;
  localparam int PHASE_SAMPLES = 197;
  localparam int NUM_PHASES    = 8;
  localparam int LONG_HOLD     = 400;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic                       cfg_we    = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_GAIN_A0;
  logic [COEF_WIDTH-1:0]      cfg_wdata = '0;

  int n_pending;
  int n_checked;
  int n_errors;

  int samples_sent   = 0;
  int settings_used  = 0;
  bit tx_idle        = 1'b1;
  bit rx_idle        = 1'b1;

  always #6 clk = ~clk;

  biquad_highpass_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  bqhp_checker filter_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .n_pending  (n_pending),
    .n_checked  (n_checked),
    .n_errors   (n_errors)
  );

  // offer one sample request, optionally after a random gap; tvalid stays
  // high when the next request follows with no gap
  task automatic send_sample(input logic [15:0] s);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
  endtask

  // wait until every output sample of the phase has been taken, block idle
  task automatic drain_filter();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // back-to-back register writes, cfg_we held high across them
  task automatic program_filter(input logic [31:0] a0, input logic [31:0] b1,
                                input logic [31:0] b2, input bit spare);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GAIN_A0;
    cfg_wdata <= a0;
    @(posedge clk);
    cfg_index <= REG_FEEDBACK_B1;
    cfg_wdata <= b1;
    @(posedge clk);
    cfg_index <= REG_FEEDBACK_B2;
    cfg_wdata <= b2;
    @(posedge clk);
    if (spare) begin
      // write to the unused index, must leave the coefficients alone
      cfg_index <= REG_SPARE;
      cfg_wdata <= $urandom();
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // random coefficient set: mostly stable pole pairs, some fully random words
  task automatic pick_setting(input int kind, output logic [31:0] a0,
                              output logic [31:0] b1, output logic [31:0] b2);
    real r;
    real theta;
    r     = 0.3 + 0.69 * $urandom_range(0, 1000) / 1000.0;
    theta = 3.14159265 * $urandom_range(0, 1000) / 1000.0;
    // poles at r*exp(+-j*theta): b1 = 2r*cos(theta), b2 = -r^2 in q2.30
    b1 = $rtoi(2.0 * r * $cos(theta) * 1073741824.0);
    b2 = -$rtoi(r * r * 1073741824.0);
    a0 = $urandom_range(0, 32'h4000_0000);
    if ($urandom_range(0, 3) == 0) a0 = -a0;
    case (kind)
      1: begin
        // anything goes, state saturation is likely
        a0 = $urandom();
        b1 = $urandom();
        b2 = $urandom();
      end
      2: a0 = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] draw_sample();
    // mostly full-range words, sometimes small values near zero
    if ($urandom_range(0, 9) < 7) return 16'($urandom());
    return 16'($urandom_range(0, 1023) - 512);
  endfunction

  // result side: random stalls, toggling stretches without stalls, and two
  // long hold-offs so the filter fills up and stalls its input
  initial begin : result_side
    int taken;
    int gap;
    taken = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, 19) : 0;
      if (taken == 120 || taken == 1000) gap = LONG_HOLD;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
      if (taken % 150 == 0) rx_idle = !rx_idle;
    end
  end

  // overall time limit, far above the slowest legal run
  initial begin : time_limit
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] a0;
    logic [31:0] b1;
    logic [31:0] b2;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset coefficients: gain zero, output stays zero while state follows x
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    drain_filter();

    // butterworth highpass at fs/8, plus a write to the unused index
    program_filter(32'd610998032, 32'd1012333480, -32'sd357913941, 1'b1);
    repeat (3) send_sample(16'h7FFF);
    repeat (3) send_sample(16'h8000);
    repeat (2) begin
      send_sample(16'h7FFF);
      send_sample(16'h8000);
    end
    drain_filter();

    // extreme, unstable coefficients: state and output both saturate
    program_filter(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    repeat (3) begin
      send_sample(16'h7FFF);
      send_sample(16'h8000);
    end
    drain_filter();

    // the opposite corners of each coefficient
    program_filter(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h8000);
    drain_filter();

    // random part: one coefficient setting per phase, sender stalls on even phases
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      tx_idle = (phase % 2 == 0);
      pick_setting(phase % 4, a0, b1, b2);
      program_filter(a0, b1, b2, phase == 3);
      repeat (PHASE_SAMPLES) send_sample(draw_sample());
      drain_filter();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("filtered %0d samples under %0d coefficient settings", samples_sent,
             settings_used);
    $display("%0d output samples compared, reset, extreme and unstable settings included",
             n_checked);
    if (n_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
